// ===== rtl/core/gcl_pkg.sv =====
// ----------------------------------------------------------------------------
// gcl_pkg: shared types and constants for the gcd/lcm unit
// Result widths, controller state encoding and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gcl_pkg;

  localparam int GCD_WIDTH = 32;
  localparam int LCM_WIDTH = 64;
  localparam int IN_WIDTH  = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GCD_DIV,
    ST_SWAP,
    ST_LCM_DIV,
    ST_MUL,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;         // capture new operands
    logic div_init;     // start a division
    logic div_src_lcm;  // 0: x / y (euclid), 1: a / x (lcm)
    logic div_step;     // one restoring-division bit
    logic swap;         // x <= y, y <= remainder
    logic mul;          // product <= quotient * b
    logic out_load;     // move result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic div_last;
  } stat_t;

endpackage

// ===== rtl/core/gcd_lcm_unit.sv =====
// ----------------------------------------------------------------------------
// gcd_lcm_unit: greatest common divisor and least common multiple
// Euclidean gcd with an exact double-width lcm; one result beat per input
// beat; a new item is computed while the last result waits for out_ready.
// ----------------------------------------------------------------------------
// Send two unsigned operands on the in_ channel and take one result beat on
// the out_ channel: the gcd, the lcm (a/gcd)*b exact at 64 bits, and
// out_zero_error, which flags both operands zero (gcd 0, lcm 0). If only one
// operand is zero the gcd is the other operand and the lcm is 0. Only the
// low OPERAND_WIDTH bits of each operand are used. A single restoring
// divider, one quotient bit per cycle, sets the latency; it serves every
// Euclidean step and the lcm division, and a multiply then forms the lcm.
// The number of remainder iterations is at most about 47 for 32-bit
// operands, typically a handful. The block takes a new beat only once the
// previous item has moved into the output register, so a stalled result
// beat does not hold back the next item's computation.
// ----------------------------------------------------------------------------
module gcd_lcm_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [gcl_pkg::IN_WIDTH-1:0]    in_operand_a,
  input  logic [gcl_pkg::IN_WIDTH-1:0]    in_operand_b,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gcl_pkg::GCD_WIDTH-1:0]   out_gcd_value,
  output logic [gcl_pkg::LCM_WIDTH-1:0]   out_lcm_value,
  output logic                            out_zero_error
);

  gcl_pkg::cmd_t  cmd;
  gcl_pkg::stat_t stat;

  // drop operand bits above the configured width
  logic [OPERAND_WIDTH-1:0] opa, opb;
  assign opa = in_operand_a[OPERAND_WIDTH-1:0];
  assign opb = in_operand_b[OPERAND_WIDTH-1:0];

  gcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gcl_dpath #(
    .W (OPERAND_WIDTH)
  ) u_dpath (
    .clk     (clk),
    .opa     (opa),
    .opb     (opb),
    .cmd     (cmd),
    .stat    (stat),
    .gcd_out (out_gcd_value),
    .lcm_out (out_lcm_value),
    .err_out (out_zero_error)
  );

endmodule

// ===== rtl/core/gcl_ctrl.sv =====
// ----------------------------------------------------------------------------
// gcl_ctrl: sequencer for the gcd/lcm unit
// Steps the Euclidean loop, the lcm division and the multiply, and owns
// both channel handshakes.
// ----------------------------------------------------------------------------
module gcl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  gcl_pkg::stat_t  stat,
  output gcl_pkg::cmd_t   cmd
);

  gcl_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == gcl_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gcl_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = gcl_pkg::ST_CHECK;
      end
      gcl_pkg::ST_CHECK: begin
        if (!stat.y_zero)     state_nxt = gcl_pkg::ST_GCD_DIV;
        else if (stat.x_zero) state_nxt = gcl_pkg::ST_FINISH;
        else                  state_nxt = gcl_pkg::ST_LCM_DIV;
      end
      gcl_pkg::ST_GCD_DIV: begin
        if (stat.div_last) state_nxt = gcl_pkg::ST_SWAP;
      end
      gcl_pkg::ST_SWAP: state_nxt = gcl_pkg::ST_CHECK;
      gcl_pkg::ST_LCM_DIV: begin
        if (stat.div_last) state_nxt = gcl_pkg::ST_MUL;
      end
      gcl_pkg::ST_MUL: state_nxt = gcl_pkg::ST_FINISH;
      gcl_pkg::ST_FINISH: begin
        if (out_free) state_nxt = gcl_pkg::ST_IDLE;
      end
      default: state_nxt = gcl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      gcl_pkg::ST_IDLE: cmd.load = in_valid;
      gcl_pkg::ST_CHECK: begin
        cmd.div_init    = !stat.y_zero || !stat.x_zero;
        cmd.div_src_lcm = stat.y_zero;
      end
      gcl_pkg::ST_GCD_DIV: cmd.div_step = 1'b1;
      gcl_pkg::ST_SWAP:    cmd.swap = 1'b1;
      gcl_pkg::ST_LCM_DIV: cmd.div_step = 1'b1;
      gcl_pkg::ST_MUL:     cmd.mul = 1'b1;
      gcl_pkg::ST_FINISH:  cmd.out_load = out_free;
      default:             cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)     out_valid_nxt = 1'b1;
    else if (out_ready)   out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gcl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/gcl_dpath.sv =====
// ----------------------------------------------------------------------------
// gcl_dpath: datapath for the gcd/lcm unit
// Euclid registers, a shared one-bit-per-cycle restoring divider, the
// quotient-by-operand multiplier and the output register.
// ----------------------------------------------------------------------------
module gcl_dpath #(
  parameter int W = 32
) (
  input  logic                            clk,
  input  logic [W-1:0]                    opa,
  input  logic [W-1:0]                    opb,
  input  gcl_pkg::cmd_t                   cmd,
  output gcl_pkg::stat_t                  stat,
  output logic [gcl_pkg::GCD_WIDTH-1:0]   gcd_out,
  output logic [gcl_pkg::LCM_WIDTH-1:0]   lcm_out,
  output logic                            err_out
);

  localparam int CW = $clog2(W);
  localparam int GW = gcl_pkg::GCD_WIDTH;
  localparam int LW = gcl_pkg::LCM_WIDTH;

  logic [W-1:0]    a_r, b_r, x_r, y_r;
  logic [W-1:0]    rem_r, quo_r, dvs_r;
  logic [CW-1:0]   cnt_r;
  logic [2*W-1:0]  prod_r;
  logic [GW-1:0]   gcd_r;
  logic [LW-1:0]   lcm_r;
  logic            err_r;

  logic [W:0]      shifted, diff;
  logic            ge;
  logic [W-1:0]    rem_nxt, quo_nxt;

  // restoring step: shift in the next dividend bit, subtract when it fits
  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = !diff[W];
  assign rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
  assign quo_nxt = {quo_r[W-2:0], ge};

  assign stat.x_zero   = (x_r == '0);
  assign stat.y_zero   = (y_r == '0);
  assign stat.div_last = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= opa;
      b_r <= opb;
      x_r <= opa;
      y_r <= opb;
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      cnt_r <= CW'(W - 1);
      if (cmd.div_src_lcm) begin
        quo_r <= a_r;
        dvs_r <= x_r;
      end else begin
        quo_r <= x_r;
        dvs_r <= y_r;
      end
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.swap) begin
      x_r <= y_r;
      y_r <= rem_r;
    end
    if (cmd.mul) begin
      prod_r <= quo_r * b_r;
    end
    if (cmd.out_load) begin
      gcd_r <= GW'(x_r);
      err_r <= stat.x_zero;
      lcm_r <= stat.x_zero ? '0 : LW'(prod_r);
    end
  end

  assign gcd_out = gcd_r;
  assign lcm_out = lcm_r;
  assign err_out = err_r;

endmodule
